@@ sv/lat_pkg.sv @@
// Shared types and constants for the toroidal Life grid block.
package lat_pkg;

  // Field widths fixed by the item format
  localparam int unsigned COORD_W = 10;
  localparam int unsigned LIVE_W  = 13;
  localparam logic [LIVE_W-1:0] COUNT_MAX = 13'h1FFF;

  // Life rule: neighbor counts for birth and for survival
  localparam logic [3:0] BIRTH_CNT   = 4'd3;
  localparam logic [3:0] SURVIVE_CNT = 4'd2;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_TOGGLE = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_PAUSE  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_GEN,
    ST_READ,
    ST_FINISH
  } state_e;

  // Per-cycle control broadcast to every column cell
  typedef struct packed {
    logic shift;      // move window down one row
    logic save;       // keep incoming bit as the saved top row
    logic use_saved;  // shift in the saved top row instead of memory data
  } cell_ctrl_t;

endpackage

@@ sv/lat_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lat_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/lat_cell.sv @@
// One column cell: a three-row window of its column plus the saved top row.
module lat_cell (
  input  logic                clk_i,
  input  lat_pkg::cell_ctrl_t ctrl_i,
  input  logic                din_i,    // new row bit from memory
  input  logic [2:0]          left_i,   // left neighbor window {down, mid, up}
  input  logic [2:0]          right_i,  // right neighbor window
  output logic [2:0]          col_o,    // own window {down, mid, up}
  output logic                nxt_o     // next state of the center cell
);

  logic up_q, mid_q, dn_q, sav_q;
  logic [3:0] nsum;

  // Window shifts down as rows stream through
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      up_q  <= mid_q;
      mid_q <= dn_q;
      dn_q  <= ctrl_i.use_saved ? sav_q : din_i;
    end
    if (ctrl_i.save) begin
      sav_q <= din_i;
    end
  end

  assign col_o = {dn_q, mid_q, up_q};

  // Eight-neighbor count and Life rule
  always_comb begin
    nsum = 4'(left_i[0]) + 4'(left_i[1]) + 4'(left_i[2])
         + 4'(right_i[0]) + 4'(right_i[1]) + 4'(right_i[2])
         + 4'(up_q) + 4'(dn_q);
    nxt_o = (nsum == lat_pkg::BIRTH_CNT) || ((nsum == lat_pkg::SURVIVE_CNT) && mid_q);
  end

endmodule

@@ sv/lat_popcount.sv @@
// Registered adder tree counting the set bits of one row.
module lat_popcount #(
  parameter int unsigned N = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [N-1:0]           bits_i,
  output logic [$clog2(N+1)-1:0] sum_o
);

  localparam int unsigned SW   = $clog2(N + 1);
  localparam int unsigned NPAD = 1 << $clog2(N);

  // Heap layout: nodes 1..NPAD-1 registered, NPAD..2*NPAD-1 are leaves
  logic [SW-1:0] node_q [1:NPAD-1];
  logic [SW-1:0] tree_w [1:2*NPAD-1];

  for (genvar k = 1; k < NPAD; k++) begin : g_node
    assign tree_w[k] = node_q[k];
  end

  for (genvar j = 0; j < NPAD; j++) begin : g_leaf
    if (j < N) begin : g_used
      assign tree_w[NPAD+j] = SW'(bits_i[j]);
    end else begin : g_pad
      assign tree_w[NPAD+j] = '0;
    end
  end

  // One level of additions per register stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k < NPAD; k++) begin
        node_q[k] <= '0;
      end
    end else begin
      for (int k = 1; k < NPAD; k++) begin
        node_q[k] <= tree_w[2*k] + tree_w[2*k+1];
      end
    end
  end

  assign sum_o = node_q[1];

endmodule

@@ sv/life_automaton_toroidal.sv @@
// Top level: toroidal Life grid with a chain of column cells.
// Usage: present kind_i, cell_x_i, cell_y_i with start high while busy is
// low; that edge is the input transfer. Exactly one result follows per item:
// valid_o is high for one cycle with cell_value_o, live_count_o, paused_o,
// and the result transfer happens at the end of that cycle. The receiver
// cannot stall; results are never held back.
// Path from start edge to valid_o: toggle, pause and paused tick go through READ and
// FINISH, with valid_o registered after FINISH; clear first passes CLEAR, a running tick GEN.
// A running tick streams one grid row per cycle out of the row RAM into the cell chain
// and back, and GEN also covers the window fill and the row count tree depth.
// busy is high from the input transfer until the result cycle, so the next
// item may be started in the cycle valid_o is high.
// Reset: the grid RAM is swept to all dead rows, one row per cycle,
// with busy high; pause is set and the live count is zero.
module life_automaton_toroidal #(
  parameter int unsigned GRID_COLS = 64,
  parameter int unsigned GRID_ROWS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   kind_i,
  input  logic [lat_pkg::COORD_W-1:0]  cell_x_i,
  input  logic [lat_pkg::COORD_W-1:0]  cell_y_i,
  output logic                         valid_o,
  output logic                         cell_value_o,
  output logic [lat_pkg::LIVE_W-1:0]   live_count_o,
  output logic                         paused_o
);

  localparam int unsigned XW       = $clog2(GRID_COLS);
  localparam int unsigned YW       = $clog2(GRID_ROWS);
  localparam int unsigned SW       = $clog2(GRID_COLS + 1);
  localparam int unsigned CNT_W    = $clog2(GRID_COLS * GRID_ROWS + 1);
  localparam int unsigned EXT_W    = (CNT_W > lat_pkg::LIVE_W) ? CNT_W : lat_pkg::LIVE_W;
  localparam int unsigned TREE_LAT = $clog2(GRID_COLS);
  localparam int unsigned GEN_LAST = GRID_ROWS + 3 + TREE_LAT;
  localparam int unsigned CW       = $clog2(GEN_LAST + 1);

  lat_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  lat_pkg::kind_e  kind_q;
  logic [lat_pkg::COORD_W-1:0] cx_q, cy_q;
  logic            in_range_q;
  logic            paused_q, paused_d;
  logic [CNT_W-1:0] alive_q, alive_d;
  logic            valid_q, valid_d;
  logic            cell_value_q, cell_value_d;
  logic [lat_pkg::LIVE_W-1:0] live_count_q, live_count_d;

  logic            accept;
  logic            in_range;
  logic [XW-1:0]   cx_idx;
  logic [YW-1:0]   cy_idx;
  logic [GRID_COLS-1:0] toggle_mask;
  logic            cur_bit;
  logic [EXT_W-1:0] alive_ext;

  // RAM and chain controls
  logic            ram_we, ram_re;
  logic [YW-1:0]   ram_waddr, ram_raddr;
  logic [GRID_COLS-1:0] ram_wdata, ram_rdata;
  lat_pkg::cell_ctrl_t cell_ctrl;
  logic            gen_wr;
  logic [GRID_COLS-1:0] next_row;
  logic [GRID_COLS-1:0] count_bits;
  logic [SW-1:0]   row_sum;
  logic [2:0]      col_w [GRID_COLS];

  assign busy   = (state_q != lat_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign in_range = ({1'b0, cell_x_i} < (lat_pkg::COORD_W + 1)'(GRID_COLS))
                 && ({1'b0, cell_y_i} < (lat_pkg::COORD_W + 1)'(GRID_ROWS));
  assign cx_idx = cx_q[XW-1:0];
  assign cy_idx = cy_q[YW-1:0];

  // Row memory
  lat_ram #(
    .WIDTH (GRID_COLS),
    .DEPTH (GRID_ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Chain of column cells, wrapping left and right
  for (genvar i = 0; i < GRID_COLS; i++) begin : g_cell
    localparam int unsigned LEFT  = (i + GRID_COLS - 1) % GRID_COLS;
    localparam int unsigned RIGHT = (i + 1) % GRID_COLS;
    lat_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .din_i   (ram_rdata[i]),
      .left_i  (col_w[LEFT]),
      .right_i (col_w[RIGHT]),
      .col_o   (col_w[i]),
      .nxt_o   (next_row[i])
    );
  end

  // Live cells of each new row, counted only while it is written
  assign count_bits = gen_wr ? next_row : '0;

  lat_popcount #(
    .N (GRID_COLS)
  ) u_popcount (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .bits_i (count_bits),
    .sum_o  (row_sum)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lat_pkg::ST_INIT: begin
        if (cnt_q == CW'(GRID_ROWS - 1)) state_d = lat_pkg::ST_IDLE;
      end
      lat_pkg::ST_IDLE: begin
        if (start) begin
          case (lat_pkg::kind_e'(kind_i))
            lat_pkg::KIND_TICK:  state_d = paused_q ? lat_pkg::ST_READ : lat_pkg::ST_GEN;
            lat_pkg::KIND_CLEAR: state_d = lat_pkg::ST_CLEAR;
            default:             state_d = lat_pkg::ST_READ;
          endcase
        end
      end
      lat_pkg::ST_CLEAR: begin
        if (cnt_q == CW'(GRID_ROWS - 1)) state_d = lat_pkg::ST_READ;
      end
      lat_pkg::ST_GEN: begin
        if (cnt_q == CW'(GEN_LAST)) state_d = lat_pkg::ST_READ;
      end
      lat_pkg::ST_READ:   state_d = lat_pkg::ST_FINISH;
      lat_pkg::ST_FINISH: state_d = lat_pkg::ST_IDLE;
      default:            state_d = lat_pkg::ST_INIT;
    endcase
  end

  // Datapath controls and register updates
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    cell_ctrl = '0;
    gen_wr    = 1'b0;
    cnt_d     = '0;
    paused_d  = paused_q;
    alive_d   = alive_q;
    valid_d   = 1'b0;
    cell_value_d = cell_value_q;
    live_count_d = live_count_q;
    toggle_mask  = '0;
    cur_bit      = 1'b0;
    alive_ext    = '0;

    case (state_q)
      lat_pkg::ST_INIT, lat_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = YW'(cnt_q);
        cnt_d     = (state_d == state_q) ? cnt_q + CW'(1) : '0;
      end
      lat_pkg::ST_IDLE: begin
        if (accept) begin
          case (lat_pkg::kind_e'(kind_i))
            lat_pkg::KIND_TICK: begin
              if (!paused_q) alive_d = '0;
            end
            lat_pkg::KIND_PAUSE: paused_d = !paused_q;
            lat_pkg::KIND_CLEAR: begin
              paused_d = 1'b1;
              alive_d  = '0;
            end
            default: ;
          endcase
        end
      end
      lat_pkg::ST_GEN: begin
        // Feed order: last row, rows 0..last, then the saved row 0
        ram_re    = (cnt_q <= CW'(GRID_ROWS));
        ram_raddr = (cnt_q == '0) ? YW'(GRID_ROWS - 1) : YW'(cnt_q - CW'(1));
        cell_ctrl.shift     = (cnt_q >= CW'(1)) && (cnt_q <= CW'(GRID_ROWS + 2));
        cell_ctrl.save      = (cnt_q == CW'(2));
        cell_ctrl.use_saved = (cnt_q == CW'(GRID_ROWS + 2));
        // Window is complete in the cycle after each shift from feed two on
        gen_wr    = (cnt_q >= CW'(4)) && (cnt_q <= CW'(GRID_ROWS + 3));
        ram_we    = gen_wr;
        ram_waddr = YW'(cnt_q - CW'(4));
        ram_wdata = next_row;
        alive_d   = alive_q + CNT_W'(row_sum);
        cnt_d     = (state_d == state_q) ? cnt_q + CW'(1) : '0;
      end
      lat_pkg::ST_READ: begin
        ram_re    = 1'b1;
        ram_raddr = cy_idx;
      end
      lat_pkg::ST_FINISH: begin
        toggle_mask[cx_idx] = 1'b1;
        cur_bit = in_range_q && ram_rdata[cx_idx];
        if ((kind_q == lat_pkg::KIND_TOGGLE) && in_range_q) begin
          ram_we    = 1'b1;
          ram_waddr = cy_idx;
          ram_wdata = ram_rdata ^ toggle_mask;
          alive_d   = cur_bit ? alive_q - CNT_W'(1) : alive_q + CNT_W'(1);
          cur_bit   = !cur_bit;
        end
        alive_ext    = EXT_W'(alive_d);
        valid_d      = 1'b1;
        cell_value_d = cur_bit;
        live_count_d = (alive_ext > EXT_W'(lat_pkg::COUNT_MAX)) ? lat_pkg::COUNT_MAX
                                                               : lat_pkg::LIVE_W'(alive_ext);
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lat_pkg::ST_INIT;
      cnt_q    <= '0;
      paused_q <= 1'b1;
      alive_q  <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      paused_q <= paused_d;
      alive_q  <= alive_d;
      valid_q  <= valid_d;
    end
  end

  // Item capture and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= lat_pkg::kind_e'(kind_i);
      cx_q       <= cell_x_i;
      cy_q       <= cell_y_i;
      in_range_q <= in_range;
    end
    cell_value_q <= cell_value_d;
    live_count_q <= live_count_d;
  end

  assign valid_o      = valid_q;
  assign cell_value_o = cell_value_q;
  assign live_count_o = live_count_q;
  assign paused_o     = paused_q;

endmodule
